FILE: rtl/mts_pkg.sv
// Package: shared types and codes for the min-tracking stack.
package mts_pkg;

   localparam int unsigned DATA_W = 32;

   // Operation codes carried on the request channel
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } mts_op_type;

   // Status codes carried on the response channel
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } mts_status_type;

   // One stack entry: stored value and the running minimum down to the bottom
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] min;
   } mts_entry_type;

   // Shift control broadcast to every cell of the chain
   typedef struct packed {
      logic push;
      logic pop;
   } mts_shift_type;

endpackage

FILE: rtl/mts_if.sv
// Interfaces: request and response channels of the min-tracking stack.
interface mts_req_if
   import mts_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface mts_rsp_if
   import mts_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] popped_value;
   logic signed [DATA_W-1:0] current_min;
   logic                     is_empty;
   logic                     is_full;
   logic [1:0]               status;

   modport source (output valid, output popped_value, output current_min,
                   output is_empty, output is_full, output status, input ready);
   modport sink   (input valid, input popped_value, input current_min,
                   input is_empty, input is_full, input status, output ready);
endinterface

FILE: rtl/mts_cell.sv
// Module: one cell of the stack chain, holding a single entry.
module mts_cell
   import mts_pkg::*;
(
   input  logic          clock,
   input  mts_shift_type shift,
   input  mts_entry_type above_in,
   input  mts_entry_type below_in,
   output mts_entry_type entry
);

   mts_entry_type entry_ff;
   mts_entry_type entry_in;

   // Take the entry above on push, the entry below on pop, else hold
   always_comb begin
      entry_in = entry_ff;
      if (shift.push) begin
         entry_in = above_in;
      end else if (shift.pop) begin
         entry_in = below_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/min_tracking_stack.sv
// Top level: min-tracking LIFO stack built from a chain of shifting cells.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-------------------------------------------
//   req_if   | in  | valid/ready       | op, value
//   rsp_if   | out | valid/ready       | popped_value, current_min, is_empty,
//            |     |                   | is_full, status
//
// One transaction per cycle while the response side keeps up: the top of stack sits in
// cell 0 and every cell shifts towards its neighbour on a successful push or pop, so no
// operation needs more than cell 0, cell 1 and the entry count. The response is registered
// and appears in the cycle after acceptance. A request is taken whenever the response
// register is empty or being drained. Synchronous reset empties the stack at once; cell
// contents are left as they are and are never read before being pushed.
module min_tracking_stack
   import mts_pkg::*;
#(
   parameter int unsigned DEPTH = 128
)(
   input  logic        clock,
   input  logic        reset,
   mts_req_if.sink     req_if,
   mts_rsp_if.source   rsp_if
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_popped_ff;
   logic signed [DATA_W-1:0] rsp_popped_in;
   logic signed [DATA_W-1:0] rsp_min_ff;
   logic signed [DATA_W-1:0] rsp_min_in;
   logic           rsp_empty_ff;
   logic           rsp_empty_in;
   logic           rsp_full_ff;
   logic           rsp_full_in;
   mts_status_type rsp_status_ff;
   mts_status_type rsp_status_in;

   logic           accept;
   logic           is_push;
   logic           at_full;
   logic           at_empty;
   mts_shift_type  shift;
   mts_entry_type  new_entry;
   mts_entry_type  cells [DEPTH];
   mts_entry_type  below_top;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign is_push      = (mts_op_type'(req_if.op) == OP_PUSH);
   assign at_full      = (count_ff == CW'(DEPTH));
   assign at_empty     = (count_ff == '0);

   // Form the entry to push: new value with the lower of it and the minimum below
   always_comb begin
      new_entry.value = req_if.value;
      new_entry.min   = req_if.value;
      if (!at_empty && ($signed(cells[0].min) < $signed(req_if.value))) begin
         new_entry.min = cells[0].min;
      end
   end

   assign shift.push = accept && is_push && !at_full;
   assign shift.pop  = accept && !is_push && !at_empty;

   // Build the cell chain; cell 0 is the top of stack
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         mts_entry_type above_e;
         mts_entry_type below_e;
         if (gi == 0) begin : g_top
            assign above_e = new_entry;
         end else begin : g_mid
            assign above_e = cells[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_bottom
            assign below_e = '0;
         end else begin : g_upper
            assign below_e = cells[gi+1];
         end
         mts_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .above_in (above_e),
            .below_in (below_e),
            .entry    (cells[gi])
         );
      end
   endgenerate

   assign below_top = cells[1];

   // Update the entry count and load the response register
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_popped_in = rsp_popped_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_popped_in = '0;
         rsp_status_in = ST_OK;
         if (is_push) begin
            if (at_full) begin
               rsp_status_in = ST_OVERFLOW;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end else begin
            if (at_empty) begin
               rsp_status_in = ST_UNDERFLOW;
            end else begin
               count_in      = count_ff - CW'(1);
               rsp_popped_in = cells[0].value;
            end
         end
         // Minimum after the operation
         if (shift.push) begin
            rsp_min_in = new_entry.min;
         end else if (shift.pop) begin
            rsp_min_in = (count_ff > CW'(1)) ? below_top.min : '0;
         end else begin
            rsp_min_in = at_empty ? '0 : cells[0].min;
         end
         rsp_empty_in = (count_in == '0);
         rsp_full_in  = (count_in == CW'(DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      rsp_popped_ff <= rsp_popped_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.popped_value = rsp_popped_ff;
   assign rsp_if.current_min  = rsp_min_ff;
   assign rsp_if.is_empty     = rsp_empty_ff;
   assign rsp_if.is_full      = rsp_full_ff;
   assign rsp_if.status       = rsp_status_ff;

   // Count stays within the stack depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   // A successful push grows the stack by exactly one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      shift.push |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not advance the count");

   // An overflow is only reported against a full stack
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_OVERFLOW) |-> rsp_full_ff)
      else $error("overflow without full flag");

   // An empty stack reports a zero minimum
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_min_ff == '0)
      else $error("empty stack with non-zero minimum");

endmodule

FILE: verif/tb.sv
// Testbench for the min-tracking stack: self-checking scoreboard, random traffic and back-pressure.
`timescale 1ns / 100ps

module tb;
   import mts_pkg::*;

   localparam int unsigned STACK_DEPTH = 128;

   // One response transaction as the scoreboard sees it
   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic signed [DATA_W-1:0] current_min;
      logic                     is_empty;
      logic                     is_full;
      mts_status_type           status;
   } stack_outcome_type;

   // Shadow stack: tracks the contents and queues the response each request must produce
   class min_stack_shadow;
      logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
      logic signed [DATA_W-1:0] min_mem [STACK_DEPTH];
      int unsigned              fill;
      stack_outcome_type        outcomes [$];
      int unsigned              errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      function int unsigned pending();
         return outcomes.size();
      endfunction

      // Apply an accepted request and queue the response it should give
      function void apply_operation(mts_op_type op, logic signed [DATA_W-1:0] value);
         stack_outcome_type o;
         o.popped_value = '0;
         o.status       = ST_OK;
         if (op == OP_PUSH) begin
            if (fill == STACK_DEPTH) begin
               o.status = ST_OVERFLOW;
            end else begin
               value_mem[fill] = value;
               // running minimum: the smaller of the new value and the one below
               min_mem[fill] = (fill != 0 && min_mem[fill-1] < value) ? min_mem[fill-1] : value;
               fill++;
            end
         end else if (fill == 0) begin
            o.status = ST_UNDERFLOW;
         end else begin
            fill--;
            o.popped_value = value_mem[fill];
         end
         o.current_min = (fill != 0) ? min_mem[fill-1] : '0;
         o.is_empty    = (fill == 0);
         o.is_full     = (fill == STACK_DEPTH);
         outcomes.push_back(o);
      endfunction

      // Compare a response with the oldest queued one, field by field
      function void check_outcome(stack_outcome_type got);
         stack_outcome_type want;
         if (outcomes.size() == 0) begin
            $error("unexpected response: popped_value %0d current_min %0d status %0d",
                   got.popped_value, got.current_min, got.status);
            errors++;
            return;
         end
         want = outcomes.pop_front();
         if (got.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0d, got %0d", want.popped_value, got.popped_value);
            errors++;
         end
         if (got.current_min !== want.current_min) begin
            $error("current_min: expected %0d, got %0d", want.current_min, got.current_min);
            errors++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            errors++;
         end
         if (got.is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   mts_req_if req_if ();
   mts_rsp_if rsp_if ();

   min_stack_shadow shadow = new();

   min_tracking_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Clock generation
   always #5 clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Push value: full range, small values near zero, extremes and mid magnitudes
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0, 1, 2: return $urandom;
         3, 4:    return $signed($urandom_range(0, 400)) - 200;
         5:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         6:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
         default: return $signed($urandom) >>> $urandom_range(0, 31);
      endcase
   endfunction

   // Offer one request, hold it until accepted, then idle for the given gap
   task automatic send_op(input mts_op_type op, input logic signed [DATA_W-1:0] value,
                          input int unsigned gap);
      req_if.op    <= op;
      req_if.value <= value;
      req_if.valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_if.ready);
      shadow.apply_operation(op, value);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stimulus
   initial begin
      int unsigned push_pct [14] = '{55, 90, 95, 10, 50, 92, 5, 60, 97, 40, 8, 70, 93, 15};
      int unsigned gap;
      mts_op_type  op;

      clock        = 1'b0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.op    = OP_PUSH;
      req_if.value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: underflow on empty, extremes, equal and repeated minima
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_PUSH, 32'sh7FFF_FFFF,   pick_gap());
      send_op(OP_PUSH, 32'sh8000_0000,   pick_gap());
      send_op(OP_PUSH, 32'sd0,           pick_gap());
      send_op(OP_PUSH, -32'sd1,          pick_gap());
      send_op(OP_POP,  32'shFFFF_FFFF,   pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_POP,  32'sh5555_5555,   pick_gap());
      send_op(OP_PUSH, 32'sd5,           pick_gap());
      send_op(OP_PUSH, 32'sd5,           pick_gap());
      send_op(OP_PUSH, 32'sd3,           pick_gap());
      send_op(OP_PUSH, 32'sd7,           pick_gap());
      send_op(OP_PUSH, 32'sd3,           pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_PUSH, -32'sd100,        pick_gap());
      send_op(OP_PUSH, 32'sd100,         pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());
      send_op(OP_POP,  32'sd0,           pick_gap());

      // Random: segments biased to fill, drain or churn the stack
      for (int seg = 0; seg < 14; seg++) begin
         // pause until every outstanding response has come back
         if (seg == 7) begin
            req_if.valid <= 1'b0;
            while (shadow.pending() != 0) @(posedge clock);
         end
         for (int i = 0; i < 100; i++) begin
            op  = ($urandom_range(0, 99) < push_pct[seg]) ? OP_PUSH : OP_POP;
            gap = (seg % 3 == 0) ? 0 : pick_gap();
            send_op(op, pick_value(), gap);
         end
      end

      // Drain and finish
      req_if.valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (shadow.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Response side: check each transaction, then decide ready for the next cycle
   initial begin
      int unsigned       outcome_count;
      int unsigned       stall_left;
      bit                long_hold_done;
      stack_outcome_type got;

      outcome_count  = 0;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_if.ready   = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.popped_value = rsp_if.popped_value;
            got.current_min  = rsp_if.current_min;
            got.is_empty     = rsp_if.is_empty;
            got.is_full      = rsp_if.is_full;
            got.status       = mts_status_type'(rsp_if.status);
            shadow.check_outcome(got);
            outcome_count++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!long_hold_done && outcome_count >= 600) begin
            // hold off long enough for the block to back up and stall its input
            long_hold_done = 1'b1;
            stall_left     = 299;
            rsp_if.ready  <= 1'b0;
         end else if ((outcome_count / 150) % 3 == 1) begin
            rsp_if.ready <= 1'b1;
         end else if ($urandom_range(0, 99) < 65) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left    = pick_gap();
         end
      end
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
